// ===== rtl/core/pmq_pkg.sv =====
// Shared types and constants of the priority message queue.
package pmq_pkg;

  // Built queue depth and derived counter width
  localparam int unsigned QDepth = 64;
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  // Field widths
  localparam int unsigned PrioW  = 15;
  localparam int unsigned LenW   = 14;
  localparam int unsigned HdlW   = 16;
  localparam int unsigned BytesW = 20;

  // Largest message length the block ever accepts
  localparam logic [LenW-1:0] SizeLimit = 14'd8192;

  // Register reset values
  localparam logic [6:0]      MaxMsgRst  = 7'd10;
  localparam logic [LenW-1:0] MaxSizeRst = 14'd8192;

  // Configuration register indexes
  localparam logic CFG_MAX_MSG  = 1'b0;
  localparam logic CFG_MAX_SIZE = 1'b1;

  // Operation codes
  localparam logic [1:0] OP_SEND    = 2'd0;
  localparam logic [1:0] OP_RECV    = 2'd1;
  localparam logic [1:0] OP_ARM     = 2'd2;
  localparam logic [1:0] OP_DISARM  = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_PRIO = 3'd1;
  localparam logic [2:0] ST_TOO_LONG = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_SMALL    = 3'd5;
  localparam logic [2:0] ST_BUSY     = 3'd6;

  // One message descriptor
  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [LenW-1:0]  len;
    logic [HdlW-1:0]  handle;
  } entry_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t ent;
  } cell_ctl_t;

endpackage

// ===== rtl/core/pmq_cell.sv =====
// One slot of the sorted descriptor chain.
module pmq_cell (
  input  logic               clk_i,
  input  logic               occupied_i,
  input  pmq_pkg::cell_ctl_t ctl_i,
  input  pmq_pkg::entry_t    left_i,
  input  logic               left_ge_i,
  input  pmq_pkg::entry_t    right_i,
  output logic               ge_o,
  output pmq_pkg::entry_t    entry_o
);

  pmq_pkg::entry_t entry_q, entry_d;

  // Held entry stays ahead of the new one (FIFO among equal priorities)
  assign ge_o = occupied_i && (entry_q.prio >= ctl_i.ent.prio);

  // Insert: keep, take the new item, or shift in from the left; pop shifts from the right
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins) begin
      if (ge_o) begin
        entry_d = entry_q;
      end else if (left_ge_i) begin
        entry_d = ctl_i.ent;
      end else begin
        entry_d = left_i;
      end
    end else if (ctl_i.pop) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/core/priority_message_queue.sv =====
// Top level of the priority message queue: control, counters and the cell chain.
// The queue holds up to 64 message descriptors in a chain of cells kept sorted,
// highest priority at the head and first in, first out within one priority. Every
// item (send, receive, arm, disarm) is decided combinationally: all cells compare
// their priority against a sent item in parallel and shift in the same edge, so an
// item can be accepted every cycle while the output register is free or being
// drained. Each item gives one result with status, popped descriptor, message
// count, queued bytes and the notification flag. No clearing pass is needed after
// reset. Configuration registers are written through a simple write port and take
// effect for the next item.
module priority_message_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] message_handle_i,
  input  logic [15:0] length_i,
  input  logic [15:0] priority_req_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] out_handle_o,
  output logic [13:0] out_length_o,
  output logic [14:0] out_priority_o,
  output logic [6:0]  message_count_o,
  output logic [19:0] queued_bytes_o,
  output logic        notify_fired_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [13:0] cfg_data_i
);

  localparam int unsigned Depth = pmq_pkg::QDepth;
  localparam int unsigned CntW  = pmq_pkg::CntW;
  localparam int unsigned LenW  = pmq_pkg::LenW;
  localparam int unsigned BytW  = pmq_pkg::BytesW;

  // Configuration registers
  logic [6:0]      max_msg_q;
  logic [LenW-1:0] max_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_msg_q  <= pmq_pkg::MaxMsgRst;
      max_size_q <= pmq_pkg::MaxSizeRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pmq_pkg::CFG_MAX_MSG:  max_msg_q  <= cfg_data_i[6:0];
        pmq_pkg::CFG_MAX_SIZE: max_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [BytW-1:0] bytes_q, bytes_d;
  logic            armed_q, armed_d;

  // Output register
  logic                  out_valid_q;
  logic [2:0]            status_q, status_d;
  pmq_pkg::entry_t       pop_q, pop_d;
  logic                  fired_q, fired_d;

  logic accept;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Effective limits
  logic [CntW-1:0] cap;
  logic [LenW-1:0] lim;
  assign cap = (CntW'(max_msg_q) > CntW'(Depth)) ? CntW'(Depth) : CntW'(max_msg_q);
  assign lim = (max_size_q > pmq_pkg::SizeLimit) ? pmq_pkg::SizeLimit : max_size_q;

  // Cell chain
  pmq_pkg::cell_ctl_t ctl;
  pmq_pkg::entry_t    ent [Depth];
  logic               ge  [Depth];
  pmq_pkg::entry_t    head;

  assign head = ent[0];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    pmq_pkg::entry_t left_ent, right_ent;
    logic            left_ge;
    if (i == 0) begin : g_first
      assign left_ent = ctl.ent;
      assign left_ge  = 1'b1;
    end else begin : g_mid
      assign left_ent = ent[i-1];
      assign left_ge  = ge[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign right_ent = ent[i];
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end
    pmq_cell u_cell (
      .clk_i      (clk_i),
      .occupied_i (CntW'(i) < cnt_q),
      .ctl_i      (ctl),
      .left_i     (left_ent),
      .left_ge_i  (left_ge),
      .right_i    (right_ent),
      .ge_o       (ge[i]),
      .entry_o    (ent[i])
    );
  end

  // Item decode and result
  always_comb begin
    cnt_d    = cnt_q;
    bytes_d  = bytes_q;
    armed_d  = armed_q;
    status_d = pmq_pkg::ST_OK;
    pop_d    = '0;
    fired_d  = 1'b0;
    ctl.ins  = 1'b0;
    ctl.pop  = 1'b0;
    ctl.ent.prio   = priority_req_i[14:0];
    ctl.ent.len    = length_i[LenW-1:0];
    ctl.ent.handle = message_handle_i;
    case (operation_i)
      pmq_pkg::OP_SEND: begin
        if (priority_req_i[15]) begin
          status_d = pmq_pkg::ST_BAD_PRIO;
        end else if (length_i > {2'b00, lim}) begin
          status_d = pmq_pkg::ST_TOO_LONG;
        end else if (cnt_q >= cap) begin
          status_d = pmq_pkg::ST_FULL;
        end else begin
          ctl.ins = accept;
          cnt_d   = cnt_q + 1'b1;
          bytes_d = bytes_q + BytW'(length_i);
          if (cnt_q == '0 && armed_q) begin
            armed_d = 1'b0;
            fired_d = 1'b1;
          end
        end
      end
      pmq_pkg::OP_RECV: begin
        if (length_i < {2'b00, lim}) begin
          status_d = pmq_pkg::ST_SMALL;
        end else if (cnt_q == '0) begin
          status_d = pmq_pkg::ST_EMPTY;
        end else begin
          ctl.pop = accept;
          pop_d   = head;
          cnt_d   = cnt_q - 1'b1;
          bytes_d = (bytes_q >= BytW'(head.len)) ? bytes_q - BytW'(head.len) : '0;
        end
      end
      pmq_pkg::OP_ARM: begin
        if (armed_q) begin
          status_d = pmq_pkg::ST_BUSY;
        end else begin
          armed_d = 1'b1;
        end
      end
      default: begin
        armed_d = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      bytes_q     <= '0;
      armed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q   <= cnt_d;
        bytes_q <= bytes_d;
        armed_q <= armed_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      pop_q    <= pop_d;
      fired_q  <= fired_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign out_handle_o    = pop_q.handle;
  assign out_length_o    = pop_q.len;
  assign out_priority_o  = pop_q.prio;
  assign message_count_o = cnt_q;
  assign queued_bytes_o  = bytes_q;
  assign notify_fired_o  = fired_q;

  // Count never passes the built depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("message count above depth");

  // A successful send adds exactly one message
  a_send_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && operation_i == pmq_pkg::OP_SEND && status_d == pmq_pkg::ST_OK
    |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("send did not add one message");

  // Notification only fires on the first message
  a_fire_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && fired_q |-> cnt_q == CntW'(1) && !armed_q)
    else $error("notification fired on a non-empty queue");

  // Failed items leave popped fields clear
  a_fail_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != pmq_pkg::ST_OK |-> pop_q == '0 && !fired_q)
    else $error("failed item carries descriptor data");

endmodule
